### src/pib_pkg.sv
`default_nettype none

package pib_pkg;

    // Geometry of the output palette store.
    localparam int unsigned PAL_DEPTH = 256;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned COLOR_W   = 24;

    // Configuration register indexes.
    localparam logic CFG_SPRITE_MODE     = 1'b0;
    localparam logic CFG_TRANSPARENT_KEY = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_FOUND       = 2'd0,
        ST_ADDED       = 2'd1,
        ST_FULL        = 2'd2,
        ST_TRANSPARENT = 2'd3
    } pib_result_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_WAIT
    } pib_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // latch a new pixel and set up the search
        logic search;  // advance the search by one entry
        logic finish;  // commit the result and load the output register
    } pib_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // the current pixel's result is known
        logic out_full;  // the output register holds an untaken result
    } pib_stat_t;

endpackage

`default_nettype wire

### src/pib_ctrl.sv
`default_nettype none

module pib_ctrl
    import pib_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic      out_stall,
    input  wire pib_stat_t stat,
    output pib_cmd_t       cmd
);

    pib_state_t state_reg;
    pib_state_t state_next;
    logic       out_free;

    // The output register can take a result when empty or being emptied.
    assign out_free = !stat.out_full || !out_stall;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!stat.done)
                begin
                    cmd.search = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/pib_dp.sv
`default_nettype none

module pib_dp
    import pib_pkg::*;
#(
    parameter int MAX_ENTRIES = 255
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pib_cmd_t           cmd,
    output pib_stat_t               stat,
    input  wire logic [7:0]         source_index,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic [IDX_W-1:0]        color_index,
    output logic [1:0]              status,
    output logic [IDX_W-1:0]        entries_used
);

    localparam logic [IDX_W-1:0] MAX_COUNT = IDX_W'(MAX_ENTRIES);

    // Palette store, undefined until written.
    logic [COLOR_W-1:0] mem [PAL_DEPTH];

    logic               sprite_mode_reg;
    logic [7:0]         transparent_key_reg;
    logic [IDX_W-1:0]   used_count_reg;
    logic [IDX_W-1:0]   used_count_next;
    logic [COLOR_W-1:0] color_reg;
    logic               trans_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_valid_reg;
    logic [COLOR_W-1:0] rdata_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;
    pib_result_t        out_status_reg;
    logic [IDX_W-1:0]   out_count_reg;

    logic               hit;
    logic               miss;
    logic               rd_en;
    logic [IDX_W-1:0]   start_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   res_index;
    pib_result_t        res_status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_mode_reg     <= 1'b0;
            transparent_key_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SPRITE_MODE:     sprite_mode_reg     <= cfg_data[0];
                CFG_TRANSPARENT_KEY: transparent_key_reg <= cfg_data;
                default:             sprite_mode_reg     <= sprite_mode_reg;
            endcase
        end
    end

    // Entry 0 is reserved for transparent pixels in sprite mode.
    assign start_addr = {{(IDX_W-1){1'b0}}, sprite_mode_reg};

    // Search status: each compare checks the read data registered in the cycle before.
    assign hit   = !trans_reg && cmp_valid_reg && (rdata_reg == color_reg);
    assign miss  = !trans_reg && !cmp_valid_reg && (rd_addr_reg >= used_count_reg);
    assign rd_en = cmd.search && (rd_addr_reg < used_count_reg);

    assign stat.done     = trans_reg || hit || miss;
    assign stat.out_full = out_valid_reg;

    // Result selection and allocation at the first free entry.
    always_comb
    begin
        wr_addr         = (used_count_reg < start_addr) ? start_addr : used_count_reg;
        wr_en           = 1'b0;
        used_count_next = used_count_reg;
        res_index       = '0;
        res_status      = ST_FULL;
        if (trans_reg)
        begin
            res_status = ST_TRANSPARENT;
        end
        else if (hit)
        begin
            res_index  = cmp_idx_reg;
            res_status = ST_FOUND;
        end
        else if (used_count_reg >= MAX_COUNT)
        begin
            res_status = ST_FULL;
        end
        else
        begin
            res_index       = wr_addr;
            res_status      = ST_ADDED;
            wr_en           = cmd.finish;
            used_count_next = wr_addr + IDX_W'(1);
        end
    end

    // Pixel capture and search pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_reg     <= 1'b0;
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            trans_reg     <= sprite_mode_reg && (source_index == transparent_key_reg);
            rd_addr_reg   <= start_addr;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.search)
        begin
            cmp_valid_reg <= rd_en;
            if (rd_en)
            begin
                rd_addr_reg <= rd_addr_reg + IDX_W'(1);
            end
        end
    end

    // Payload registers of the search.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            color_reg <= {red, green, blue};
        end
        if (cmd.search && rd_en)
        begin
            cmp_idx_reg <= rd_addr_reg;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= color_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            used_count_reg <= used_count_next;
        end
    end

    // Output register, holding a transaction until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_index_reg  <= res_index;
            out_status_reg <= res_status;
            out_count_reg  <= used_count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign color_index  = out_index_reg;
    assign status       = out_status_reg;
    assign entries_used = out_count_reg;

endmodule

`default_nettype wire

### src/palette_index_builder.sv
// Flow: a pixel is latched when taken, stored entries are read and compared one by one until a hit
// or a miss, and the result is then loaded into the output register, waiting while it is full.
// One pixel is handled at a time; the linear search through the palette memory, one compare a
// cycle, sets the pace. A new pixel is taken while a result waits.
// Reset clears the entry count, the configuration and the handshake state at once;
// the palette memory is not cleared, as entries are read only below the count.
`default_nettype none

module palette_index_builder
    import pib_pkg::*;
#(
    parameter int MAX_ENTRIES = 255
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] source_index,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      color_index,
    output logic [1:0]      status,
    output logic [7:0]      entries_used,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    pib_cmd_t  cmd;
    pib_stat_t stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    pib_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Palette store, search and result registers.
    pib_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .source_index (source_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .color_index  (color_index),
        .status       (status),
        .entries_used (entries_used)
    );

endmodule

`default_nettype wire
